// ===== design/cam_pkg.sv =====
package cam_pkg;

  // sequencer phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_OP1  = 3'd1,
    PH_OP2  = 3'd2,
    PH_PLO  = 3'd3,
    PH_PHI  = 3'd4,
    PH_DATA = 3'd5
  } phase_t;

  // input word kinds
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  // result word kinds
  localparam logic RES_REQUEST = 1'b0;
  localparam logic RES_DONE    = 1'b1;

  // addressing modes
  localparam logic [3:0] MODE_IMM  = 4'd0;
  localparam logic [3:0] MODE_ZP   = 4'd1;
  localparam logic [3:0] MODE_ZPX  = 4'd2;
  localparam logic [3:0] MODE_ZPY  = 4'd3;
  localparam logic [3:0] MODE_REL  = 4'd4;
  localparam logic [3:0] MODE_ABS  = 4'd5;
  localparam logic [3:0] MODE_ABSX = 4'd6;
  localparam logic [3:0] MODE_ABSY = 4'd7;
  localparam logic [3:0] MODE_IND  = 4'd8;
  localparam logic [3:0] MODE_INDX = 4'd9;
  localparam logic [3:0] MODE_INDY = 4'd10;
  localparam logic [3:0] MODE_LAST = MODE_INDY;

  localparam logic [15:0] PTR_STEP = 16'h0001;

endpackage

// ===== design/cpu_addressing_mode_unit.sv =====
// a result word is registered: it is valid in the cycle after the input word that causes it
// throughput: one input word per cycle while in_stall is low; a new word is taken while a result waits
//   in the output register and is taken in the same cycle
// the sequencer state and output register update in one pass of address adders
// reset: synchronous active-high rst returns the sequencer to idle, clears the
//   latched operand state and empties the output register
module cpu_addressing_mode_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        item_kind,
  input  logic [3:0]  mode,
  input  logic [15:0] pc_start,
  input  logic [7:0]  index_x,
  input  logic [7:0]  index_y,
  input  logic [7:0]  read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [15:0] address,
  output logic [7:0]  data_value,
  output logic [15:0] next_pc
);

  cam_pkg::phase_t phase, phase_next;
  logic [3:0]  mode_held, mode_held_next;
  logic [15:0] pc_held, pc_held_next;
  logic [7:0]  x_held, x_held_next;
  logic [7:0]  y_held, y_held_next;
  logic [7:0]  low_byte, low_byte_next;
  logic [15:0] pointer, pointer_next;

  logic        accept;
  logic        emit;
  logic        res_kind;
  logic [15:0] res_addr;
  logic [7:0]  res_data;
  logic [15:0] res_npc;

  logic [15:0] pc1, pc2;
  logic [15:0] base;
  logic [15:0] rel_off;
  logic        start_bad;

  // input side is free when the output register is empty or drains now
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign pc1       = pc_held + 16'd1;
  assign pc2       = pc_held + 16'd2;
  assign base      = {read_data, low_byte};
  assign rel_off   = {{8{read_data[7]}}, read_data};
  assign start_bad = (mode > cam_pkg::MODE_LAST);

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (item_kind == cam_pkg::KIND_START) begin
        phase_next = start_bad ? cam_pkg::PH_IDLE : cam_pkg::PH_OP1;
      end else begin
        case (phase)
          cam_pkg::PH_IDLE: phase_next = cam_pkg::PH_IDLE;
          cam_pkg::PH_OP1: begin
            if (mode_held == cam_pkg::MODE_INDX || mode_held == cam_pkg::MODE_INDY)
              phase_next = cam_pkg::PH_PLO;
            else if (mode_held == cam_pkg::MODE_ABS || mode_held == cam_pkg::MODE_ABSX ||
                     mode_held == cam_pkg::MODE_ABSY || mode_held == cam_pkg::MODE_IND)
              phase_next = cam_pkg::PH_OP2;
            else
              phase_next = cam_pkg::PH_IDLE;
          end
          cam_pkg::PH_OP2: begin
            phase_next = (mode_held == cam_pkg::MODE_IND) ? cam_pkg::PH_PLO
                                                          : cam_pkg::PH_IDLE;
          end
          cam_pkg::PH_PLO: phase_next = cam_pkg::PH_PHI;
          cam_pkg::PH_PHI: begin
            phase_next = (mode_held == cam_pkg::MODE_IND) ? cam_pkg::PH_IDLE
                                                          : cam_pkg::PH_DATA;
          end
          default: phase_next = cam_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // result word and held operand state
  always_comb begin
    mode_held_next = mode_held;
    pc_held_next   = pc_held;
    x_held_next    = x_held;
    y_held_next    = y_held;
    low_byte_next  = low_byte;
    pointer_next   = pointer;
    emit           = 1'b0;
    res_kind       = cam_pkg::RES_REQUEST;
    res_addr       = 16'd0;
    res_data       = 8'd0;
    res_npc        = 16'd0;
    if (accept) begin
      if (item_kind == cam_pkg::KIND_START) begin
        emit = 1'b1;
        if (start_bad) begin
          res_kind = cam_pkg::RES_DONE;
          res_addr = pc_start;
          res_npc  = pc_start;
        end else begin
          mode_held_next = mode;
          pc_held_next   = pc_start;
          x_held_next    = index_x;
          y_held_next    = index_y;
          res_addr       = pc_start;
        end
      end else begin
        case (phase)
          cam_pkg::PH_IDLE: emit = 1'b0;
          cam_pkg::PH_OP1: begin
            emit = 1'b1;
            case (mode_held)
              cam_pkg::MODE_IMM: begin
                res_kind = cam_pkg::RES_DONE;
                res_addr = pc_held;
                res_data = read_data;
                res_npc  = pc1;
              end
              cam_pkg::MODE_ZP: begin
                res_kind = cam_pkg::RES_DONE;
                res_addr = {8'd0, read_data};
                res_npc  = pc1;
              end
              cam_pkg::MODE_ZPX: begin
                res_kind = cam_pkg::RES_DONE;
                res_addr = {8'd0, read_data + x_held};
                res_npc  = pc1;
              end
              cam_pkg::MODE_ZPY: begin
                res_kind = cam_pkg::RES_DONE;
                res_addr = {8'd0, read_data + y_held};
                res_npc  = pc1;
              end
              cam_pkg::MODE_REL: begin
                res_kind = cam_pkg::RES_DONE;
                res_addr = pc1 + rel_off;
                res_npc  = pc1;
              end
              cam_pkg::MODE_INDX: begin
                pointer_next = {8'd0, read_data + x_held};
                res_addr     = {8'd0, read_data + x_held};
              end
              cam_pkg::MODE_INDY: begin
                pointer_next = {8'd0, read_data};
                res_addr     = {8'd0, read_data};
              end
              default: begin
                low_byte_next = read_data;
                res_addr      = pc1;
              end
            endcase
          end
          cam_pkg::PH_OP2: begin
            emit = 1'b1;
            case (mode_held)
              cam_pkg::MODE_ABSX: begin
                res_kind = cam_pkg::RES_DONE;
                res_addr = base + {8'd0, x_held};
                res_npc  = pc2;
              end
              cam_pkg::MODE_ABSY: begin
                res_kind = cam_pkg::RES_DONE;
                res_addr = base + {8'd0, y_held};
                res_npc  = pc2;
              end
              cam_pkg::MODE_IND: begin
                pointer_next = base;
                res_addr     = base;
              end
              default: begin
                res_kind = cam_pkg::RES_DONE;
                res_addr = base;
                res_npc  = pc2;
              end
            endcase
          end
          cam_pkg::PH_PLO: begin
            emit          = 1'b1;
            low_byte_next = read_data;
            res_addr      = pointer + cam_pkg::PTR_STEP;
          end
          cam_pkg::PH_PHI: begin
            emit = 1'b1;
            if (mode_held == cam_pkg::MODE_IND) begin
              res_kind = cam_pkg::RES_DONE;
              res_addr = base;
              res_npc  = pc2;
            end else if (mode_held == cam_pkg::MODE_INDY) begin
              pointer_next = base + {8'd0, y_held};
              res_addr     = base + {8'd0, y_held};
            end else begin
              pointer_next = base;
              res_addr     = base;
            end
          end
          cam_pkg::PH_DATA: begin
            emit     = 1'b1;
            res_kind = cam_pkg::RES_DONE;
            res_addr = pointer;
            res_data = read_data;
            res_npc  = pc1;
          end
          default: emit = 1'b0;
        endcase
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= cam_pkg::PH_IDLE;
      mode_held <= 4'd0;
      pc_held   <= 16'd0;
      x_held    <= 8'd0;
      y_held    <= 8'd0;
      low_byte  <= 8'd0;
      pointer   <= 16'd0;
    end else begin
      phase     <= phase_next;
      mode_held <= mode_held_next;
      pc_held   <= pc_held_next;
      x_held    <= x_held_next;
      y_held    <= y_held_next;
      low_byte  <= low_byte_next;
      pointer   <= pointer_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register word
  always_ff @(posedge clk) begin
    if (emit) begin
      result_kind <= res_kind;
      address     <= res_addr;
      data_value  <= res_data;
      next_pc     <= res_npc;
    end
  end

  // request words never carry operand data or a pc
  a_req_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == cam_pkg::RES_REQUEST |-> data_value == 8'd0 && next_pc == 16'd0)
    else $error("request word carries data or pc");

  // data phase only in indirect data modes
  a_data_mode: assert property (@(posedge clk) disable iff (rst)
    phase == cam_pkg::PH_DATA |->
      mode_held == cam_pkg::MODE_INDX || mode_held == cam_pkg::MODE_INDY)
    else $error("data phase in wrong mode");

  // high operand phase only in absolute modes and indirect mode
  a_op2_mode: assert property (@(posedge clk) disable iff (rst)
    phase == cam_pkg::PH_OP2 |->
      mode_held == cam_pkg::MODE_ABS || mode_held == cam_pkg::MODE_ABSX ||
      mode_held == cam_pkg::MODE_ABSY || mode_held == cam_pkg::MODE_IND)
    else $error("high operand phase in wrong mode");

  // a good start requests the first operand byte next cycle
  a_start_req: assert property (@(posedge clk) disable iff (rst)
    accept && item_kind == cam_pkg::KIND_START && mode <= cam_pkg::MODE_LAST |=>
      out_valid && result_kind == cam_pkg::RES_REQUEST && address == $past(pc_start) &&
      phase == cam_pkg::PH_OP1)
    else $error("start did not request first operand");

  // answer while idle is dropped
  a_idle_drop: assert property (@(posedge clk) disable iff (rst)
    accept && item_kind == cam_pkg::KIND_ANSWER && phase == cam_pkg::PH_IDLE |=>
      phase == cam_pkg::PH_IDLE)
    else $error("idle answer changed phase");

endmodule

// ===== verif/addr_mode_checker.sv =====
`timescale 1ns / 100ps
module addr_mode_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        item_kind,
  input  logic [3:0]  mode,
  input  logic [15:0] pc_start,
  input  logic [7:0]  index_x,
  input  logic [7:0]  index_y,
  input  logic [7:0]  read_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        result_kind,
  input  logic [15:0] address,
  input  logic [7:0]  data_value,
  input  logic [15:0] next_pc,
  output int          fail_count,
  output int          words_pending,
  output int          results_seen
);

  // one bus word as the unit hands it out
  typedef struct packed {
    logic        kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [15:0] npc;
  } bus_word_t;

  bus_word_t predicted_results[$];

  // shadow copy of the sequencer
  cam_pkg::phase_t seq_phase;
  logic [3:0]  mode_q;
  logic [15:0] pc_q;
  logic [7:0]  x_q;
  logic [7:0]  y_q;
  logic [7:0]  lo_q;
  logic [15:0] ptr_q;

  initial begin
    fail_count    = 0;
    words_pending = 0;
    results_seen  = 0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR: %s", msg);
    fail_count++;
  endtask

  task automatic push_request(input logic [15:0] addr);
    predicted_results.push_back('{cam_pkg::RES_REQUEST, addr, 8'h00, 16'h0000});
  endtask

  task automatic push_done(input logic [15:0] addr, input logic [7:0] data,
                           input logic [15:0] npc);
    predicted_results.push_back('{cam_pkg::RES_DONE, addr, data, npc});
    seq_phase = cam_pkg::PH_IDLE;
  endtask

  // advance the sequencer by one accepted word and queue what it yields
  task automatic advance_sequencer(input logic kind, input logic [3:0] m,
                                   input logic [15:0] pcs, input logic [7:0] x,
                                   input logic [7:0] y, input logic [7:0] d);
    logic [15:0] pc1;
    logic [15:0] pc2;
    logic [15:0] base;
    logic [15:0] ea;
    logic [7:0]  zp;
    pc1 = pc_q + 16'd1;
    pc2 = pc_q + 16'd2;
    if (kind == cam_pkg::KIND_START) begin
      if (m > cam_pkg::MODE_LAST) begin
        // undefined mode finishes at once and leaves the unit idle
        push_done(pcs, 8'h00, pcs);
      end else begin
        mode_q    = m;
        pc_q      = pcs;
        x_q       = x;
        y_q       = y;
        seq_phase = cam_pkg::PH_OP1;
        push_request(pcs);
      end
    end else begin
      case (seq_phase)
        cam_pkg::PH_OP1: begin
          case (mode_q)
            cam_pkg::MODE_IMM: push_done(pc_q, d, pc1);
            cam_pkg::MODE_ZP:  push_done({8'h00, d}, 8'h00, pc1);
            cam_pkg::MODE_ZPX: begin
              zp = d + x_q;
              push_done({8'h00, zp}, 8'h00, pc1);
            end
            cam_pkg::MODE_ZPY: begin
              zp = d + y_q;
              push_done({8'h00, zp}, 8'h00, pc1);
            end
            cam_pkg::MODE_REL: push_done(pc1 + {{8{d[7]}}, d}, 8'h00, pc1);
            cam_pkg::MODE_INDX: begin
              zp        = d + x_q;
              ptr_q     = {8'h00, zp};
              seq_phase = cam_pkg::PH_PLO;
              push_request(ptr_q);
            end
            cam_pkg::MODE_INDY: begin
              ptr_q     = {8'h00, d};
              seq_phase = cam_pkg::PH_PLO;
              push_request(ptr_q);
            end
            default: begin
              lo_q      = d;
              seq_phase = cam_pkg::PH_OP2;
              push_request(pc1);
            end
          endcase
        end
        cam_pkg::PH_OP2: begin
          base = {d, lo_q};
          if (mode_q == cam_pkg::MODE_ABSX) begin
            push_done(base + {8'h00, x_q}, 8'h00, pc2);
          end else if (mode_q == cam_pkg::MODE_ABSY) begin
            push_done(base + {8'h00, y_q}, 8'h00, pc2);
          end else if (mode_q == cam_pkg::MODE_IND) begin
            ptr_q     = base;
            seq_phase = cam_pkg::PH_PLO;
            push_request(ptr_q);
          end else begin
            push_done(base, 8'h00, pc2);
          end
        end
        cam_pkg::PH_PLO: begin
          // pointer high byte comes from pointer+1, full 16-bit carry
          lo_q      = d;
          seq_phase = cam_pkg::PH_PHI;
          push_request(ptr_q + cam_pkg::PTR_STEP);
        end
        cam_pkg::PH_PHI: begin
          ea = {d, lo_q};
          if (mode_q == cam_pkg::MODE_IND) begin
            push_done(ea, 8'h00, pc2);
          end else begin
            if (mode_q == cam_pkg::MODE_INDY) ea = ea + {8'h00, y_q};
            ptr_q     = ea;
            seq_phase = cam_pkg::PH_DATA;
            push_request(ea);
          end
        end
        cam_pkg::PH_DATA: push_done(ptr_q, d, pc1);
        // answer while idle is dropped
        default: seq_phase = cam_pkg::PH_IDLE;
      endcase
    end
  endtask

  // compare outgoing words, then predict from the incoming word
  always @(posedge clk) begin : watch
    bus_word_t want;
    if (rst) begin
      seq_phase = cam_pkg::PH_IDLE;
      mode_q    = 4'h0;
      pc_q      = 16'h0000;
      x_q       = 8'h00;
      y_q       = 8'h00;
      lo_q      = 8'h00;
      ptr_q     = 16'h0000;
      predicted_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          flag_error($sformatf("result word %0d not expected: kind %0d addr %h",
                               results_seen, result_kind, address));
        end else begin
          want = predicted_results.pop_front();
          if (result_kind !== want.kind)
            flag_error($sformatf("word %0d kind got %0d want %0d",
                                 results_seen, result_kind, want.kind));
          if (address !== want.addr)
            flag_error($sformatf("word %0d address got %h want %h",
                                 results_seen, address, want.addr));
          if (data_value !== want.data)
            flag_error($sformatf("word %0d data got %h want %h",
                                 results_seen, data_value, want.data));
          if (next_pc !== want.npc)
            flag_error($sformatf("word %0d next pc got %h want %h",
                                 results_seen, next_pc, want.npc));
        end
      end
      if (in_valid && !in_stall)
        advance_sequencer(item_kind, mode, pc_start, index_x, index_y, read_data);
    end
    words_pending <= predicted_results.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic        item_kind   = cam_pkg::KIND_START;
  logic [3:0]  mode        = cam_pkg::MODE_IMM;
  logic [15:0] pc_start    = 16'h0000;
  logic [7:0]  index_x     = 8'h00;
  logic [7:0]  index_y     = 8'h00;
  logic [7:0]  read_data   = 8'h00;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic        result_kind;
  logic [15:0] address;
  logic [7:0]  data_value;
  logic [15:0] next_pc;

  logic hold_off      = 1'b0;
  int   send_idle_pct = 28;
  int   recv_idle_pct = 58;
  int   words_sent    = 0;
  int   fail_count;
  int   words_pending;
  int   results_seen;

  cpu_addressing_mode_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .item_kind  (item_kind),
    .mode       (mode),
    .pc_start   (pc_start),
    .index_x    (index_x),
    .index_y    (index_y),
    .read_data  (read_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_kind(result_kind),
    .address    (address),
    .data_value (data_value),
    .next_pc    (next_pc)
  );

  addr_mode_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .item_kind    (item_kind),
    .mode         (mode),
    .pc_start     (pc_start),
    .index_x      (index_x),
    .index_y      (index_y),
    .read_data    (read_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .address      (address),
    .data_value   (data_value),
    .next_pc      (next_pc),
    .fail_count   (fail_count),
    .words_pending(words_pending),
    .results_seen (results_seen)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // long receiver hold-off so the unit fills and stalls its input
  initial begin
    wait (words_sent >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk);
    hold_off <= 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("ERROR: run limit reached");
    $display("Test completed with failures");
    $finish;
  end

  // field values leaning toward the extremes
  function automatic logic [7:0] pick8();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'hFFFE;
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one word after a random gap and hold it until taken
  task automatic send_word(input logic kind, input logic [3:0] m,
                           input logic [15:0] pc, input logic [7:0] x,
                           input logic [7:0] y, input logic [7:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    item_kind <= kind;
    mode      <= m;
    pc_start  <= pc;
    index_x   <= x;
    index_y   <= y;
    read_data <= d;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // unused fields are filled with noise
  task automatic send_start(input logic [3:0] m, input logic [15:0] pc,
                            input logic [7:0] x, input logic [7:0] y);
    send_word(cam_pkg::KIND_START, m, pc, x, y, 8'($urandom));
  endtask

  task automatic send_answer(input logic [7:0] d);
    send_word(cam_pkg::KIND_ANSWER, 4'($urandom), 16'($urandom), 8'($urandom),
              8'($urandom), d);
  endtask

  // one fetch: mostly complete, some cut short, some stray or undefined
  task automatic run_sequence();
    int         pick;
    int         n;
    logic [3:0] m;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 2)) send_answer(pick8());
    end else if (pick < 12) begin
      send_start(4'($urandom_range(cam_pkg::MODE_LAST + 1, 15)), pick16(), pick8(),
                 pick8());
    end else begin
      m = 4'($urandom_range(cam_pkg::MODE_IMM, cam_pkg::MODE_LAST));
      case (m)
        cam_pkg::MODE_ABS, cam_pkg::MODE_ABSX, cam_pkg::MODE_ABSY: n = 2;
        cam_pkg::MODE_IND, cam_pkg::MODE_INDX, cam_pkg::MODE_INDY: n = 4;
        default:                                                   n = 1;
      endcase
      if (pick < 20) n = $urandom_range(0, n - 1);
      send_start(m, pick16(), pick8(), pick8());
      repeat (n) send_answer(pick8());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed words
    send_answer(8'hFF);                                   // stray answer while idle
    send_start(cam_pkg::MODE_IMM, 16'hFFFF, 8'hFF, 8'hFF);  // pc wraps past the top
    send_answer(8'hFF);
    send_start(cam_pkg::MODE_ZPX, 16'h1234, 8'hFF, 8'h00);  // zero page wrap
    send_answer(8'h01);
    send_start(cam_pkg::MODE_REL, 16'h0000, 8'h00, 8'h00);  // backward branch wraps
    send_answer(8'h80);
    send_start(cam_pkg::MODE_ABSY, 16'hFFFE, 8'h00, 8'hFF); // 16-bit index wrap
    send_answer(8'hFF);
    send_answer(8'hFF);
    send_start(cam_pkg::MODE_INDY, 16'h0200, 8'h00, 8'hFF); // pointer at ff, high from 0100
    send_answer(8'hFF);
    send_answer(8'h34);
    send_answer(8'h12);
    send_answer(8'h5A);
    send_start(cam_pkg::MODE_INDX, 16'h0300, 8'hFF, 8'h00); // pointer wraps to 00
    send_answer(8'h01);
    send_answer(8'h00);
    send_answer(8'h80);
    send_answer(8'h7F);
    send_start(4'hF, 16'hABCD, 8'h55, 8'hAA);               // undefined mode
    send_start(cam_pkg::MODE_IND, 16'h4000, 8'h00, 8'h00);  // cut short by the next start
    send_answer(8'hFF);
    send_start(cam_pkg::MODE_ABSX, 16'h5000, 8'hFF, 8'h00);
    send_answer(8'h01);
    send_answer(8'hFF);

    // random fetches in three idling regimes
    while (words_sent < 1250) begin
      if (words_sent >= 840) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (words_sent >= 420) begin
        send_idle_pct = 58;
        recv_idle_pct = 28;
      end
      run_sequence();
    end
    in_valid <= 1'b0;

    // drain
    for (int i = 0; i < 5000 && words_pending != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (words_pending != 0)
      $display("ERROR: %0d expected result words never arrived", words_pending);

    $display("run: %0d input words, %0d result words compared", words_sent, results_seen);
    $display("covered all eleven modes, undefined modes, stray answers, "
             , "restarts mid-fetch and a long output hold-off");
    if (fail_count == 0 && words_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
